### src/sha256_pkg.sv
package sha256_pkg;

  localparam int BlockBytes = 64;
  localparam int WordCount  = 16;
  localparam int RoundCount = 64;

  typedef logic [31:0] word_t;
  typedef logic [5:0]  byte_idx_t;
  typedef logic [3:0]  word_idx_t;
  typedef logic [5:0]  round_idx_t;

  // Control from sequencer to round engine
  typedef struct packed {
    logic start;      // load working vars from hash, begin 64 rounds
    logic init_hash;  // reset hash words to initial values
  } eng_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;       // pulses when hash words have been updated
  } eng_stat_t;

  function automatic word_t round_k(input round_idx_t t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### src/sha256_byte_stream_hasher_unit.sv
// Channel | signals                                    | transfer
// input   | msg_byte, byte_present, end_of_message     | in_valid & in_ready
// output  | digest_word, word_index, last_word         | out_valid & out_ready
// Bytes are taken only while the sequencer is idle; every 64th byte holds the input
// until the block is done (feed with the first 16 rounds, 48 rounds, hash update, done).
// End of message writes 1 to 14 pad words and 2 length words, then a block;
// an overflowing length adds 1-2 pad words, a block and 14 zero words first.
// Then eight digest transactions and the S_INIT state that reloads the initial hash.
// rst clears control and loads initial hash; input stalls while any is busy.
module sha256_byte_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  eng_ctrl_t ctrl;
  eng_stat_t stat;
  logic      w_valid;
  word_t     w_in, rd_word;
  logic [2:0] rd_idx;

  sha256_unit_ctrl u_ctrl (
    .clk, .rst, .msg_byte, .byte_present, .end_of_message, .in_valid, .in_ready,
    .digest_word, .word_index, .last_word, .out_valid, .out_ready,
    .ctrl, .w_valid, .w_in, .stat, .rd_idx, .rd_word
  );

  sha256_engine u_engine (
    .clk, .rst, .ctrl, .w_valid, .w_in, .stat, .rd_idx, .rd_word
  );

endmodule

### src/sha256_engine.sv
// Compression engine: schedule window and working variables, one round a cycle unless waiting for a message word.
// Message words are fed in during rounds 0..15 from the block memory.
module sha256_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::eng_ctrl_t  ctrl,
  input  logic                   w_valid,
  input  sha256_pkg::word_t      w_in,
  output sha256_pkg::eng_stat_t  stat,
  input  logic [2:0]             rd_idx,
  output sha256_pkg::word_t      rd_word
);
  import sha256_pkg::*;

  word_t      hash [8];
  word_t      sched [WordCount];
  word_t      a, b, c, d, e, f, g, h;
  round_idx_t round;
  logic       running;
  logic       finish;
  logic       done;

  word_t w_cur, s0, s1, t1, t2, w_new;

  // Schedule word for this round: supplied word early, expanded later
  always_comb begin
    s1 = rotr(sched[14], 17) ^ rotr(sched[14], 19) ^ (sched[14] >> 10);
    s0 = rotr(sched[1], 7) ^ rotr(sched[1], 18) ^ (sched[1] >> 3);
    w_new = s1 + sched[9] + s0 + sched[0];
    w_cur = (round < 6'd16) ? w_in : w_new;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + round_k(round) + w_cur;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  // Advance one round per cycle; rounds below 16 wait for a message word
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      finish  <= 1'b0;
      round   <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= init_h(3'(i));
    end else if (ctrl.init_hash) begin
      for (int i = 0; i < 8; i++) hash[i] <= init_h(3'(i));
    end else if (ctrl.start) begin
      running <= 1'b1;
      round   <= '0;
      {a, b, c, d, e, f, g, h} <= {hash[0], hash[1], hash[2], hash[3],
                                   hash[4], hash[5], hash[6], hash[7]};
    end else if (finish) begin
      finish <= 1'b0;
      hash[0] <= hash[0] + a; hash[1] <= hash[1] + b;
      hash[2] <= hash[2] + c; hash[3] <= hash[3] + d;
      hash[4] <= hash[4] + e; hash[5] <= hash[5] + f;
      hash[6] <= hash[6] + g; hash[7] <= hash[7] + h;
    end else if (running && (round >= 6'd16 || w_valid)) begin
      for (int i = 0; i < WordCount - 1; i++) sched[i] <= sched[i + 1];
      sched[WordCount - 1] <= w_cur;
      {h, g, f, e, d, c, b, a} <= {g, f, e, d + t1, c, b, a, t1 + t2};
      round <= round + 6'd1;
      if (round == 6'(RoundCount - 1)) begin
        running <= 1'b0;
        finish  <= 1'b1;
      end
    end
  end

  // Pulse done on the cycle the hash words take the round result
  always_ff @(posedge clk) begin
    done <= !rst && !ctrl.init_hash && !ctrl.start && finish;
  end

  assign stat.busy = running | finish;
  assign stat.done = done;
  assign rd_word   = hash[rd_idx];

endmodule

### src/sha256_unit_ctrl.sv
// Sequencer: byte buffer memory, padding, block feed and digest output.
module sha256_unit_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             msg_byte,
  input  logic                   byte_present,
  input  logic                   end_of_message,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic [31:0]            digest_word,
  output logic [2:0]             word_index,
  output logic                   last_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sha256_pkg::eng_ctrl_t  ctrl,
  output logic                   w_valid,
  output sha256_pkg::word_t      w_in,
  input  sha256_pkg::eng_stat_t  stat,
  output logic [2:0]             rd_idx,
  input  sha256_pkg::word_t      rd_word
);
  import sha256_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FEED, S_WAIT, S_PAD, S_LEN, S_OUT, S_INIT
  } state_t;

  // Block memory: 16 words of 32 bits, one write and one read per cycle
  word_t mem [WordCount];
  logic  mem_we;
  word_idx_t mem_waddr, mem_raddr;
  word_t mem_wdata, mem_rdata;

  state_t      state;
  byte_idx_t   fill;
  byte_idx_t   fill_next;
  logic [63:0] msg_bits;
  word_t       acc;          // bytes of the word being assembled
  logic        final_blk;    // current block is the last of the message
  logic        pad_more;     // another pad block follows this one
  logic        zero_blk;     // pad block holds only zeros ahead of the length
  word_idx_t   feed_cnt;
  word_idx_t   pad_cnt;
  logic [2:0]  out_cnt;
  logic        rd_pend;
  eng_ctrl_t   ctrl_next;

  logic        take;
  word_t       acc_byte;
  word_t       pad_word;
  logic [63:0] total;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  assign in_ready  = (state == S_IDLE);
  assign take      = in_valid && in_ready;
  assign fill_next = fill + {5'd0, byte_present};
  assign total     = msg_bits + {55'd0, fill, 3'd0};

  // Insert byte into assembling word at its big-endian lane
  always_comb begin
    acc_byte = acc;
    case (fill[1:0])
      2'd0:    acc_byte = {msg_byte, 24'd0};
      2'd1:    acc_byte[23:16] = msg_byte;
      2'd2:    acc_byte[15:8]  = msg_byte;
      default: acc_byte[7:0]   = msg_byte;
    endcase
  end

  // Padding word at pad_cnt: remaining data bytes and 0x80 right after the data, zeros elsewhere
  always_comb begin
    pad_word = '0;
    if (!zero_blk && pad_cnt == fill[5:2]) begin
      pad_word = acc;
      case (fill[1:0])
        2'd0:    pad_word = 32'h80000000;
        2'd1:    pad_word[23:0] = 24'h800000;
        2'd2:    pad_word[15:0] = 16'h8000;
        default: pad_word[7:0]  = 8'h80;
      endcase
    end
  end

  // Block memory write and feed read
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill[5:2];
    mem_wdata = acc_byte;
    case (state)
      S_IDLE: mem_we = take && byte_present && (fill[1:0] == 2'd3);
      S_PAD: begin
        mem_we    = 1'b1;
        mem_waddr = pad_cnt;
        mem_wdata = pad_word;
      end
      S_LEN: begin
        mem_we    = 1'b1;
        mem_waddr = pad_cnt;
        mem_wdata = pad_cnt[0] ? total[31:0] : total[63:32];
      end
      default: mem_we = 1'b0;
    endcase
    mem_raddr = feed_cnt;
  end

  // Engine control pulses for the next cycle
  always_comb begin
    ctrl_next = '0;
    ctrl_next.start = (take && byte_present && fill == 6'd63) ||
                      (state == S_PAD && pad_cnt == 4'd15) ||
                      (state == S_LEN && pad_cnt[0]);
    ctrl_next.init_hash = (state == S_OUT) && out_ready && (out_cnt == 3'd7);
  end

  assign w_valid     = (state == S_FEED) && rd_pend;
  assign w_in        = mem_rdata;
  assign rd_idx      = out_cnt;
  assign digest_word = rd_word;
  assign word_index  = out_cnt;
  assign last_word   = (out_cnt == 3'd7);
  assign out_valid   = (state == S_OUT);

  // Hold state and registered control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fill <= '0; msg_bits <= '0; final_blk <= 1'b0;
      pad_more <= 1'b0; zero_blk <= 1'b0; feed_cnt <= '0; pad_cnt <= '0;
      out_cnt <= '0; rd_pend <= 1'b0; ctrl <= '0;
    end else begin
      ctrl <= ctrl_next;
      case (state)
        S_IDLE: if (take) begin
          if (byte_present) acc <= acc_byte;
          if (byte_present && fill == 6'd63) begin
            // full block: compress it, then maybe finish
            msg_bits  <= msg_bits + 64'd512;
            fill      <= '0;
            final_blk <= 1'b0;
            pad_more  <= end_of_message;
            feed_cnt  <= '0;
            rd_pend   <= 1'b0;
            state     <= S_FEED;
          end else begin
            fill <= fill_next;
            if (end_of_message) begin
              zero_blk <= 1'b0;
              pad_cnt  <= fill_next[5:2];
              state    <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // write the 0x80 word then zeros up to the length words
          if (pad_cnt == 4'd13) begin
            pad_cnt <= 4'd14;
            state   <= S_LEN;
          end else if (pad_cnt == 4'd15) begin
            // length does not fit: run this block, then a zero block
            final_blk <= 1'b0;
            pad_more  <= 1'b1;
            feed_cnt  <= '0;
            rd_pend   <= 1'b0;
            state     <= S_FEED;
          end else begin
            pad_cnt <= pad_cnt + 4'd1;
          end
        end
        S_LEN: begin
          if (pad_cnt[0]) begin
            final_blk <= 1'b1;
            feed_cnt  <= '0;
            rd_pend   <= 1'b0;
            state     <= S_FEED;
          end else begin
            pad_cnt <= pad_cnt + 4'd1;
          end
        end
        S_FEED: begin
          // stream words 0..15 into the engine from the registered memory read
          rd_pend  <= 1'b1;
          feed_cnt <= feed_cnt + 4'd1;
          if (rd_pend && feed_cnt == 4'd0) state <= S_WAIT;
        end
        S_WAIT: if (stat.done) begin
          if (final_blk) begin
            out_cnt <= '0;
            state   <= S_OUT;
          end else if (pad_more) begin
            // message ended on a block boundary, or the length overflowed
            pad_more <= 1'b0;
            zero_blk <= (fill >= 6'd56);
            pad_cnt  <= '0;
            state    <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: if (out_ready) begin
          out_cnt <= out_cnt + 3'd1;
          if (out_cnt == 3'd7) begin
            fill     <= '0;
            msg_bits <= '0;
            state    <= S_INIT;
          end
        end
        S_INIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/sha256_digest_checker.sv
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          pending_words
);
  import sha256_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_entry_t;

  digest_entry_t digest_queue[$];
  logic [7:0]    msg_buf[64];
  int            buf_fill;
  logic [63:0]   msg_bits;
  logic [31:0]   hash_state[8];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run 64 rounds on msg_buf and fold into hash_state
  task automatic run_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_buf[4*t], msg_buf[4*t+1], msg_buf[4*t+2], msg_buf[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_message();
    buf_fill = 0;
    msg_bits = '0;
    for (int i = 0; i < 8; i++) hash_state[i] = init_h(i[2:0]);
  endtask

  // Absorb one input transaction, queue digest on end of message
  task automatic absorb_item(input logic [7:0] b, input logic bp, input logic eom);
    logic [63:0] total;
    if (bp) begin
      msg_buf[buf_fill] = b;
      buf_fill++;
      if (buf_fill == 64) begin
        run_block();
        msg_bits += 64'd512;
        buf_fill = 0;
      end
    end
    if (eom) begin
      total = msg_bits + 64'(buf_fill * 8);
      msg_buf[buf_fill] = 8'h80;
      for (int i = buf_fill + 1; i < 64; i++) msg_buf[i] = 8'h00;
      if (buf_fill >= 56) begin
        run_block();
        for (int i = 0; i < 56; i++) msg_buf[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_buf[63-i] = total[8*i +: 8];
      run_block();
      for (int i = 0; i < 8; i++)
        digest_queue.push_back('{word: hash_state[i], idx: i[2:0], last: (i == 7)});
      restart_message();
    end
  endtask

  initial begin
    fail_count = 0;
    pending_words = 0;
    restart_message();
  end

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    digest_entry_t exp_e;
    if (!rst) begin
      if (in_valid && in_ready) absorb_item(msg_byte, byte_present, end_of_message);
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected digest word %h idx %0d", digest_word, word_index);
        end else begin
          exp_e = digest_queue.pop_front();
          if (digest_word !== exp_e.word || word_index !== exp_e.idx ||
              last_word !== exp_e.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                       exp_e.word, exp_e.idx, exp_e.last,
                       digest_word, word_index, last_word);
          end
        end
      end
      pending_words = digest_queue.size();
    end
  end
endmodule

### bench/testbench.sv
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  msg_byte = '0;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          pending_words;
  bit          calm_phase = 1'b0;
  bit          hold_off = 1'b0;

  always #5 clk = ~clk;

  sha256_byte_stream_hasher_unit dut (.*);

  sha256_digest_checker checker_i (.*);

  // Send one transaction, with optional idle cycles ahead of it
  task automatic send_item(input logic [7:0] b, input logic bp, input logic eom);
    if (!calm_phase) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    msg_byte <= b;
    byte_present <= bp;
    end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_message(input int len, input logic tail_empty);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, (i == len - 1) && !tail_empty);
    if (tail_empty || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stalls, one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (calm_phase) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 11);
  end

  initial begin
    repeat (400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int sent;
    int len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // Directed: empty message, byte with end, extremes, padding boundaries
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h3c, 1'b1, 1'b1);
    send_message(3, 1'b1);
    calm_phase = 1'b1;
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    calm_phase = 1'b0;
    send_message(64, 1'b1);
    // Random messages with sprinkled empty items
    sent = 0;
    while (sent < 110) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(57, 70) : $urandom_range(0, 20);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1));
      end
      if (end_of_message !== 1'b1 || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
      sent += len + 1;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end
endmodule

### files.f
src/sha256_pkg.sv
src/sha256_engine.sv
src/sha256_unit_ctrl.sv
src/sha256_byte_stream_hasher_unit.sv
bench/sha256_digest_checker.sv
bench/testbench.sv
